### rtl/amdfs_pkg.sv
// Package for the adjacency-matrix depth-first walk block.
// Holds sizes, action codes and the command, result and find-first word types.
// No dependencies.
package amdfs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int DEPTH_W      = $clog2(MAX_VERTICES + 1);
  localparam int VTX_W        = 6;
  localparam int CFG_W        = 7;

  localparam logic ACT_ADD_EDGE = 1'b0;
  localparam logic ACT_RUN      = 1'b1;

  typedef struct packed {
    logic             action;
    logic [VTX_W-1:0] u_vertex;
    logic [VTX_W-1:0] v_vertex;
    logic             is_directed;
    logic [VTX_W-1:0] start_vertex;
  } cmd_t;

  typedef struct packed {
    logic [VTX_W-1:0] visited_vertex;
    logic             last;
    logic             bad_start;
  } result_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] index;
  } ffs_t;

endpackage

### rtl/adjacency_matrix_dfs.sv
// Top level of the adjacency-matrix depth-first walk block.
// Holds the row memory, the walk stack memory and the sequencer.
// Depends on amdfs_pkg and amdfs_ffs.

// A command word is taken when start is high and busy is low; busy stays high
// until the command is fully done. Add edge is a read-modify-write of one row
// for a directed edge and of two rows for an undirected one, and gives no
// result; an out-of-range edge is dropped in the accept cycle. During a run
// each vertex push is done in S_SCAN and each stack pop passes through S_POP
// and back to S_SCAN. The pace is set by the loop through the row memory: read
// a row (registered read), find its lowest unvisited neighbor, and issue the
// next read. Each visited vertex comes out as one result word, shown for
// exactly one cycle with result_valid high; the receiver cannot stall, so take
// every strobe. A bad start gives one word with bad_start and last set.
// cfg_data is the vertex count, clamped to 64; write it only while busy is low.
module adjacency_matrix_dfs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  amdfs_pkg::cmd_t               cmd,
  output logic                          result_valid,
  output amdfs_pkg::result_t            result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [amdfs_pkg::CFG_W-1:0]   cfg_data
);

  localparam int MAXV    = amdfs_pkg::MAX_VERTICES;
  localparam int ADDR_W  = amdfs_pkg::ADDR_W;
  localparam int DEPTH_W = amdfs_pkg::DEPTH_W;
  localparam int VTX_W   = amdfs_pkg::VTX_W;
  localparam int CFG_W   = amdfs_pkg::CFG_W;

  localparam logic [MAXV-1:0] ROW_ONE = MAXV'(1);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EWR1 = 3'd1;  // write u row
  localparam logic [2:0] S_ERD2 = 3'd2;  // read v row
  localparam logic [2:0] S_EWR2 = 3'd3;  // write v row
  localparam logic [2:0] S_SCAN = 3'd4;  // row of stack top is on row_q
  localparam logic [2:0] S_POP  = 3'd5;  // new stack top is on stk_q

  logic [2:0] state, state_next;

  // vertex count in use, already clamped
  logic [CFG_W-1:0] num_vertices;
  logic [MAXV-1:0]  in_use;

  // adjacency row memory; row_vld marks rows written since reset
  logic [MAXV-1:0]   rows [MAXV];
  logic [MAXV-1:0]   row_vld;
  logic [MAXV-1:0]   row_q;
  logic              row_q_vld;
  logic [MAXV-1:0]   row_eff;
  logic [ADDR_W-1:0] row_raddr;
  logic              row_we;
  logic [ADDR_W-1:0] row_waddr;
  logic [MAXV-1:0]   row_wdata;

  // walk stack memory (vertex per level)
  logic [ADDR_W-1:0] stk [MAXV];
  logic [ADDR_W-1:0] stk_q;
  logic [ADDR_W-1:0] stk_raddr;
  logic              stk_we;
  logic [ADDR_W-1:0] stk_waddr;
  logic [ADDR_W-1:0] stk_wdata;

  logic [DEPTH_W-1:0] depth, depth_next;
  logic [MAXV-1:0]    visited, visited_next;
  logic [ADDR_W-1:0]  pend, pend_next;      // vertex whose word is not yet sent
  logic [ADDR_W-1:0]  edge_u, edge_v;
  logic               edge_dir;

  logic               result_valid_next;
  amdfs_pkg::result_t result_next;

  logic               accept;
  logic               u_ok, v_ok, s_ok;
  logic [MAXV-1:0]    cand;
  amdfs_pkg::ffs_t    ffs;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  assign u_ok = (CFG_W'(cmd.u_vertex) < num_vertices);
  assign v_ok = (CFG_W'(cmd.v_vertex) < num_vertices);
  assign s_ok = (CFG_W'(cmd.start_vertex) < num_vertices);

  always_comb begin
    for (int i = 0; i < MAXV; i++) begin
      in_use[i] = (CFG_W'(i) < num_vertices);
    end
  end

  // a row never written reads as all zero
  assign row_eff = row_q_vld ? row_q : '0;
  // scanning from bit 0 each time equals resuming the scan: visited only grows
  assign cand    = row_eff & ~visited & in_use;

  amdfs_ffs u_ffs (
    .vec (cand),
    .res (ffs)
  );

  always_comb begin
    state_next        = state;
    row_raddr         = edge_u;
    row_we            = 1'b0;
    row_waddr         = edge_u;
    row_wdata         = row_eff | (ROW_ONE << edge_v);
    stk_we            = 1'b0;
    stk_waddr         = depth[ADDR_W-1:0];
    stk_wdata         = ffs.index;
    stk_raddr         = ADDR_W'(depth - DEPTH_W'(2));
    depth_next        = depth;
    visited_next      = visited;
    pend_next         = pend;
    result_valid_next = 1'b0;
    result_next       = result;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.action == amdfs_pkg::ACT_ADD_EDGE) begin
            if (u_ok && v_ok) begin
              row_raddr  = cmd.u_vertex[ADDR_W-1:0];
              state_next = S_EWR1;
            end
          end else begin
            visited_next = '0;
            depth_next   = '0;
            if (s_ok) begin
              row_raddr    = cmd.start_vertex[ADDR_W-1:0];
              visited_next = ROW_ONE << cmd.start_vertex[ADDR_W-1:0];
              pend_next    = cmd.start_vertex[ADDR_W-1:0];
              stk_we       = 1'b1;
              stk_waddr    = '0;
              stk_wdata    = cmd.start_vertex[ADDR_W-1:0];
              depth_next   = DEPTH_W'(1);
              state_next   = S_SCAN;
            end else begin
              result_valid_next          = 1'b1;
              result_next.visited_vertex = '0;
              result_next.last           = 1'b1;
              result_next.bad_start      = 1'b1;
            end
          end
        end
      end
      S_EWR1: begin
        row_we     = 1'b1;
        state_next = edge_dir ? S_IDLE : S_ERD2;
      end
      S_ERD2: begin
        // separate read cycle so a self loop sees the first write
        row_raddr  = edge_v;
        state_next = S_EWR2;
      end
      S_EWR2: begin
        row_we     = 1'b1;
        row_waddr  = edge_v;
        row_wdata  = row_eff | (ROW_ONE << edge_u);
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (ffs.found) begin
          // a new vertex means the pending one is not the last
          result_valid_next          = 1'b1;
          result_next.visited_vertex = VTX_W'(pend);
          result_next.last           = 1'b0;
          result_next.bad_start      = 1'b0;
          pend_next                  = ffs.index;
          visited_next               = visited | (ROW_ONE << ffs.index);
          stk_we                     = 1'b1;
          depth_next                 = depth + DEPTH_W'(1);
          row_raddr                  = ffs.index;
        end else begin
          depth_next = depth - DEPTH_W'(1);
          if (depth == DEPTH_W'(1)) begin
            result_valid_next          = 1'b1;
            result_next.visited_vertex = VTX_W'(pend);
            result_next.last           = 1'b1;
            result_next.bad_start      = 1'b0;
            state_next                 = S_IDLE;
          end else begin
            state_next = S_POP;
          end
        end
      end
      S_POP: begin
        row_raddr  = stk_q;
        state_next = S_SCAN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      depth        <= '0;
      result_valid <= 1'b0;
      row_vld      <= '0;
      num_vertices <= CFG_W'(MAXV);
    end else begin
      state        <= state_next;
      depth        <= depth_next;
      result_valid <= result_valid_next;
      if (row_we) begin
        row_vld[row_waddr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        num_vertices <= (cfg_data > CFG_W'(MAXV)) ? CFG_W'(MAXV) : cfg_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    visited <= visited_next;
    pend    <= pend_next;
    result  <= result_next;
    if (accept) begin
      edge_u   <= cmd.u_vertex[ADDR_W-1:0];
      edge_v   <= cmd.v_vertex[ADDR_W-1:0];
      edge_dir <= cmd.is_directed;
    end
  end

  // row memory, registered read
  always_ff @(posedge clk) begin
    if (row_we) begin
      rows[row_waddr] <= row_wdata;
    end
    row_q     <= rows[row_raddr];
    row_q_vld <= row_vld[row_raddr];
  end

  // stack memory, registered read; push and pop never touch one entry together
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk[stk_raddr];
  end

  // checks
  a_scan_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_POP) |-> (depth != '0))
    else $error("walk active with empty stack");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> (state == S_IDLE))
    else $error("last word sent while walk still running");

  a_mid_word: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> (state == S_SCAN && !result.bad_start))
    else $error("non-final word outside a walk");

  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.bad_start) |-> (result.last && result.visited_vertex == '0))
    else $error("bad start word malformed");

endmodule

### rtl/amdfs_ffs.sv
// Find-first-set over one adjacency row: lowest set bit and a found flag.
// Depends on amdfs_pkg.
module amdfs_ffs (
  input  logic [amdfs_pkg::MAX_VERTICES-1:0] vec,
  output amdfs_pkg::ffs_t                    res
);

  always_comb begin
    res.found = |vec;
    res.index = '0;
    // descending so the lowest set bit wins
    for (int i = amdfs_pkg::MAX_VERTICES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.index = amdfs_pkg::ADDR_W'(i);
      end
    end
  end

endmodule
